/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sun tracker servo commander.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int SampleW = 10;
    localparam int AngleW  = 9;
    localparam int PosW    = 11;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN       = 3'd0;
    localparam logic [2:0] CFG_DARK_THR   = 3'd1;
    localparam logic [2:0] CFG_ANGLE_MIN  = 3'd2;
    localparam logic [2:0] CFG_ANGLE_MAX  = 3'd3;
    localparam logic [2:0] CFG_MOVE_SPEED = 3'd4;
    localparam logic [2:0] CFG_HOME_VERT  = 3'd5;
    localparam logic [2:0] CFG_HOME_HORIZ = 3'd6;

    // packet constants
    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] PKT_LEN_BYTE  = 8'h07;
    localparam logic [7:0] INSTR_WRITE   = 8'h03;
    localparam logic [7:0] REG_GOAL_POS  = 8'h1E;
    localparam logic [1:0] SERVO_ID_VERT  = 2'd1;
    localparam logic [1:0] SERVO_ID_HORIZ = 2'd2;

    // byte slots inside one packet
    localparam logic [3:0] IDX_SYNC0 = 4'd0;
    localparam logic [3:0] IDX_SYNC1 = 4'd1;
    localparam logic [3:0] IDX_ID    = 4'd2;
    localparam logic [3:0] IDX_LEN   = 4'd3;
    localparam logic [3:0] IDX_INSTR = 4'd4;
    localparam logic [3:0] IDX_REG   = 4'd5;
    localparam logic [3:0] IDX_POSL  = 4'd6;
    localparam logic [3:0] IDX_POSH  = 4'd7;
    localparam logic [3:0] IDX_SPDL  = 4'd8;
    localparam logic [3:0] IDX_SPDH  = 4'd9;
    localparam logic [3:0] IDX_CHK   = 4'd10;
    localparam logic [4:0] RUN_LAST  = 5'd21;

    localparam logic [AngleW-1:0] ANGLE_RESET = 9'd150;
    // floor(x/3) = (x * 43691) >> 17 for x < 2^16
    localparam logic [15:0] RECIP_3   = 16'd43691;
    // angle*1023/300 = angle*341/100; floor(y/100) = (y * 167773) >> 24 for y < 199728
    localparam logic [8:0]  POS_MUL   = 9'd341;
    localparam logic [17:0] RECIP_100 = 18'd167773;

    typedef struct packed {
        logic [4:0]         gain;
        logic [SampleW-1:0] dark_threshold;
        logic [AngleW-1:0]  angle_min;
        logic [AngleW-1:0]  angle_max;
        logic [9:0]         move_speed;
        logic [9:0]         home_pos_vertical;
        logic [9:0]         home_pos_horizontal;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_MUL,
        DP_DIV,
        DP_UPDATE,
        DP_SCALE,
        DP_RECIP,
        DP_HOME,
        DP_EMIT
    } dp_op_t;

    typedef enum logic {
        AXIS_H,
        AXIS_V
    } axis_t;

    typedef struct packed {
        dp_op_t op;
        axis_t  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic dark;
        logic out_free;
        logic pkt_end;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_H_DIV,
        ST_H_UPD,
        ST_V_MUL,
        ST_V_DIV,
        ST_V_UPD,
        ST_A_LOAD,
        ST_A_RECIP,
        ST_A_SEND,
        ST_B_LOAD,
        ST_B_RECIP,
        ST_B_SEND
    } ctl_state_t;

endpackage

/* hw/rtl/sts_regs.sv */
// ----------------------------------------------------------------------------
// sts_regs
// Configuration register file written through the config channel.
// ----------------------------------------------------------------------------
module sts_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [9:0]    cfg_data,
    output sts_pkg::cfg_t cfg
);
    import sts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN:       cfg_next.gain                = cfg_data[4:0];
                CFG_DARK_THR:   cfg_next.dark_threshold      = cfg_data;
                CFG_ANGLE_MIN:  cfg_next.angle_min           = cfg_data[8:0];
                CFG_ANGLE_MAX:  cfg_next.angle_max           = cfg_data[8:0];
                CFG_MOVE_SPEED: cfg_next.move_speed          = cfg_data;
                CFG_HOME_VERT:  cfg_next.home_pos_vertical   = cfg_data;
                CFG_HOME_HORIZ: cfg_next.home_pos_horizontal = cfg_data;
                default:        cfg_next = cfg_reg;  // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain                <= 5'd1;
            cfg_reg.dark_threshold      <= 10'd200;
            cfg_reg.angle_min           <= 9'd100;
            cfg_reg.angle_max           <= 9'd200;
            cfg_reg.move_speed          <= 10'd68;
            cfg_reg.home_pos_vertical   <= 10'd512;
            cfg_reg.home_pos_horizontal <= 10'd560;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/sts_datapath.sv */
// ----------------------------------------------------------------------------
// sts_datapath
// Angle update arithmetic, position scaling and packet byte generation.
// ----------------------------------------------------------------------------
module sts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::cfg_t       cfg,
    input  sts_pkg::dp_cmd_t    cmd,
    output sts_pkg::dp_status_t status,
    input  logic [39:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import sts_pkg::*;

    // sample registers
    logic [SampleW-1:0] top_reg, down_reg, right_reg, left_reg;
    logic               seen_reg, seen_next;

    // arithmetic pipeline registers
    logic signed [15:0] prod_reg;
    logic [13:0]        quo_reg;
    logic               neg_reg;
    logic [AngleW-1:0]  hang_reg, hang_next;
    logic [AngleW-1:0]  vang_reg, vang_next;
    logic [17:0]        scaled_reg;
    logic [PosW-1:0]    pos_reg;
    logic [1:0]         id_reg;

    // packet state
    logic [4:0] byte_pos_reg, byte_pos_next;
    logic [3:0] pkt_idx_reg, pkt_idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_seen_reg;

    logic [SampleW-1:0] op_a, op_b;
    logic [AngleW-1:0]  cur_angle;
    logic signed [10:0] diff;
    logic signed [16:0] prod_full;
    logic [15:0]        abs_full;
    logic [30:0]        quo_full;
    logic signed [15:0] corr;
    logic signed [15:0] v_raw;
    logic signed [15:0] v_clamp;
    logic [AngleW-1:0]  new_angle;
    logic [35:0]        recip_full;
    logic [7:0]         cur_byte;
    logic               emit;
    logic               dark_now;

    assign emit = (cmd.op == DP_EMIT);

    // axis operand selection
    always_comb
    begin
        if (cmd.axis == AXIS_H)
        begin
            op_a      = top_reg;
            op_b      = down_reg;
            cur_angle = hang_reg;
        end
        else
        begin
            op_a      = right_reg;
            op_b      = left_reg;
            cur_angle = vang_reg;
        end
    end

    assign dark_now = (s_tdata[9:0]   < cfg.dark_threshold) &&
                      (s_tdata[19:10] < cfg.dark_threshold) &&
                      (s_tdata[29:20] < cfg.dark_threshold) &&
                      (s_tdata[39:30] < cfg.dark_threshold);
    assign seen_next = !dark_now;

    assign diff      = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
    assign prod_full = 17'(diff) * $signed({12'b0, cfg.gain});

    // truncating divide by three on the magnitude
    assign abs_full = prod_reg[15] ? (16'd0 - prod_reg) : prod_reg;
    assign quo_full = 31'(abs_full[14:0]) * 31'(RECIP_3);

    assign corr  = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign v_raw = $signed({7'b0, cur_angle}) - corr;

    // low clamp first, then high clamp
    always_comb
    begin
        v_clamp = v_raw;
        if (v_clamp < $signed({7'b0, cfg.angle_min}))
        begin
            v_clamp = $signed({7'b0, cfg.angle_min});
        end
        if (v_clamp > $signed({7'b0, cfg.angle_max}))
        begin
            v_clamp = $signed({7'b0, cfg.angle_max});
        end
    end
    assign new_angle = v_clamp[AngleW-1:0];

    assign hang_next = (cmd.op == DP_UPDATE && cmd.axis == AXIS_H) ? new_angle : hang_reg;
    assign vang_next = (cmd.op == DP_UPDATE && cmd.axis == AXIS_V) ? new_angle : vang_reg;

    assign recip_full = 36'(scaled_reg) * 36'(RECIP_100);

    // packet byte mux
    always_comb
    begin
        unique case (pkt_idx_reg)
            IDX_SYNC0: cur_byte = SYNC_BYTE;
            IDX_SYNC1: cur_byte = SYNC_BYTE;
            IDX_ID:    cur_byte = {6'b0, id_reg};
            IDX_LEN:   cur_byte = PKT_LEN_BYTE;
            IDX_INSTR: cur_byte = INSTR_WRITE;
            IDX_REG:   cur_byte = REG_GOAL_POS;
            IDX_POSL:  cur_byte = pos_reg[7:0];
            IDX_POSH:  cur_byte = {5'b0, pos_reg[PosW-1:8]};
            IDX_SPDL:  cur_byte = cfg.move_speed[7:0];
            IDX_SPDH:  cur_byte = {6'b0, cfg.move_speed[9:8]};
            IDX_CHK:   cur_byte = ~sum_reg;
            default:   cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        pkt_idx_next   = pkt_idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.op == DP_CAPTURE)
        begin
            byte_pos_next = 5'd0;
            pkt_idx_next  = 4'd0;
            sum_next      = 8'd0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            byte_pos_next  = (byte_pos_reg == RUN_LAST) ? 5'd0 : byte_pos_reg + 5'd1;
            pkt_idx_next   = (pkt_idx_reg == IDX_CHK) ? 4'd0 : pkt_idx_reg + 4'd1;
            // checksum covers id through speed high byte
            if (pkt_idx_reg == IDX_SYNC0 || pkt_idx_reg == IDX_SYNC1 ||
                pkt_idx_reg == IDX_CHK)
            begin
                sum_next = 8'd0;
            end
            else
            begin
                sum_next = sum_reg + cur_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b1;
            hang_reg      <= ANGLE_RESET;
            vang_reg      <= ANGLE_RESET;
            byte_pos_reg  <= 5'd0;
            pkt_idx_reg   <= 4'd0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_CAPTURE)
            begin
                seen_reg <= seen_next;
            end
            hang_reg      <= hang_next;
            vang_reg      <= vang_next;
            byte_pos_reg  <= byte_pos_next;
            pkt_idx_reg   <= pkt_idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                top_reg   <= s_tdata[9:0];
                down_reg  <= s_tdata[19:10];
                right_reg <= s_tdata[29:20];
                left_reg  <= s_tdata[39:30];
            end
            DP_MUL:
            begin
                prod_reg <= $signed(prod_full[15:0]);
            end
            DP_DIV:
            begin
                quo_reg <= quo_full[30:17];
                neg_reg <= prod_reg[15];
            end
            DP_SCALE:
            begin
                scaled_reg <= 18'(cur_angle) * 18'(POS_MUL);
                id_reg     <= (cmd.axis == AXIS_H) ? SERVO_ID_HORIZ : SERVO_ID_VERT;
            end
            DP_RECIP:
            begin
                pos_reg <= recip_full[34:24];
            end
            DP_HOME:
            begin
                pos_reg <= (cmd.axis == AXIS_H) ? {1'b0, cfg.home_pos_horizontal}
                                                : {1'b0, cfg.home_pos_vertical};
                id_reg  <= (cmd.axis == AXIS_H) ? SERVO_ID_HORIZ : SERVO_ID_VERT;
            end
            DP_EMIT:
            begin
                out_byte_reg <= cur_byte;
                out_last_reg <= (byte_pos_reg == RUN_LAST);
                out_seen_reg <= seen_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.dark     = !seen_reg;
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.pkt_end  = (pkt_idx_reg == IDX_CHK);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_seen_reg;

endmodule

/* hw/rtl/sts_ctrl.sv */
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer: steps the datapath through the angle updates (light sets only) and two packets.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sts_pkg::dp_status_t status,
    output sts_pkg::dp_cmd_t    cmd
);
    import sts_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DECIDE;
            ST_DECIDE:  state_next = status.dark ? ST_A_SEND : ST_H_DIV;
            ST_H_DIV:   state_next = ST_H_UPD;
            ST_H_UPD:   state_next = ST_V_MUL;
            ST_V_MUL:   state_next = ST_V_DIV;
            ST_V_DIV:   state_next = ST_V_UPD;
            ST_V_UPD:   state_next = ST_A_LOAD;
            ST_A_LOAD:  state_next = ST_A_RECIP;
            ST_A_RECIP: state_next = ST_A_SEND;
            ST_A_SEND:  if (status.out_free && status.pkt_end) state_next = ST_B_LOAD;
            ST_B_LOAD:  state_next = status.dark ? ST_B_SEND : ST_B_RECIP;
            ST_B_RECIP: state_next = ST_B_SEND;
            ST_B_SEND:  if (status.out_free && status.pkt_end) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = DP_NOP;
        cmd.axis = AXIS_H;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = DP_CAPTURE;
            end
            ST_DECIDE:
            begin
                // dark: vertical home first; light: horizontal correction first
                cmd.op   = status.dark ? DP_HOME : DP_MUL;
                cmd.axis = status.dark ? AXIS_V : AXIS_H;
            end
            ST_H_DIV:   cmd.op = DP_DIV;
            ST_H_UPD:   cmd.op = DP_UPDATE;
            ST_V_MUL:
            begin
                cmd.op   = DP_MUL;
                cmd.axis = AXIS_V;
            end
            ST_V_DIV:   cmd.op = DP_DIV;
            ST_V_UPD:
            begin
                cmd.op   = DP_UPDATE;
                cmd.axis = AXIS_V;
            end
            ST_A_LOAD:  cmd.op = DP_SCALE;
            ST_A_RECIP: cmd.op = DP_RECIP;
            ST_A_SEND:  if (status.out_free) cmd.op = DP_EMIT;
            ST_B_LOAD:
            begin
                cmd.op   = status.dark ? DP_HOME : DP_SCALE;
                cmd.axis = status.dark ? AXIS_H : AXIS_V;
            end
            ST_B_RECIP: cmd.op = DP_RECIP;
            ST_B_SEND:  if (status.out_free) cmd.op = DP_EMIT;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/sun_tracker_servo_commander.sv */
// ----------------------------------------------------------------------------
// sun_tracker_servo_commander
// Light sensor driven pan/tilt servo commander emitting servo packets.
// ----------------------------------------------------------------------------
// One sample set is taken at a time. In light, the sequencer runs the
// two angle updates (multiply, divide by three, clamp per axis) and,
// per packet, the position scaling before the packet's eleven bytes go
// out one per cycle while the output is not stalled; a dark set skips
// these steps and sends the home packets. The next set is taken as soon
// as the last byte sits in the output register. Output stalls hold the
// sequencer in its send states.
// ----------------------------------------------------------------------------
module sun_tracker_servo_commander (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // top_level, down_level, right_level, left_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // link_byte
    output logic        m_tlast,
    output logic        m_tuser,   // light_seen
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import sts_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    sts_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sts_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/sts_checker.sv */
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the servo commander, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("output byte changed under stall");

    // one set at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous set in work");

    // a new set is only taken once the previous run is fully queued
    a_run_done_on_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tlast)
        else $error("input taken in the middle of a byte run");

endmodule

bind sun_tracker_servo_commander sts_checker u_sts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sun tracker servo commander: light sample sets
// go in on the stream slave side, and every 22-byte servo packet run that
// comes out is checked byte by byte against a behavioral copy of the
// tracker. Register settings are changed between phases, and both stream
// sides see random idle bursts.
// ----------------------------------------------------------------------------
module tb;

    import sts_pkg::*;

    localparam int  TIMEOUT       = 10_000_000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  LONG_HOLD     = 300;
    localparam int  SETS_PER_PASS = 35;
    localparam int  RANDOM_PASSES = 8;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // packed with top_level in the low bits, as on s_tdata
    typedef struct packed {
        logic [9:0] left_level;
        logic [9:0] right_level;
        logic [9:0] down_level;
        logic [9:0] top_level;
    } light_set_t;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       last_byte;
        logic       light_seen;
    } link_beat_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data  = '0;

    // tracker copy used for prediction
    cfg_t              tracker_cfg;
    logic [AngleW-1:0] horiz_angle;
    logic [AngleW-1:0] vert_angle;

    light_set_t sample_q[$];
    link_beat_t link_bytes_due[$];

    int errors     = 0;
    int sets_taken = 0;
    int hold_at    = -1;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit idle_on    = 1'b1;
    int src_gap    = 0;
    int sink_stall = 0;

    sun_tracker_servo_commander u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic logic [AngleW-1:0] step_angle(logic [AngleW-1:0] cur,
                                                     logic [9:0] a, logic [9:0] b);
        int ia, ib, icur, corr, v, lo, hi, g;
        ia   = int'(a);
        ib   = int'(b);
        icur = int'(cur);
        g    = int'(tracker_cfg.gain);
        lo   = int'(tracker_cfg.angle_min);
        hi   = int'(tracker_cfg.angle_max);
        // signed correction, truncated toward zero
        corr = ((ia - ib) * g) / 3;
        v    = icur - corr;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v[AngleW-1:0];
    endfunction

    function automatic logic [PosW-1:0] angle_to_word(logic [AngleW-1:0] angle);
        int a;
        a = int'(angle);
        return PosW'((a * 1023) / 300);
    endfunction

    function automatic void queue_packet(logic [7:0] id, logic [PosW-1:0] pos,
                                         logic seen, logic closes_run);
        logic [7:0] body [8];
        logic [7:0] sum;
        int         i;
        body[0] = id;
        body[1] = PKT_LEN_BYTE;
        body[2] = INSTR_WRITE;
        body[3] = REG_GOAL_POS;
        body[4] = pos[7:0];
        body[5] = 8'(pos[PosW-1:8]);
        body[6] = tracker_cfg.move_speed[7:0];
        body[7] = 8'(tracker_cfg.move_speed[9:8]);
        sum = '0;
        link_bytes_due.push_back('{SYNC_BYTE, 1'b0, seen});
        link_bytes_due.push_back('{SYNC_BYTE, 1'b0, seen});
        for (i = 0; i < 8; i++)
        begin
            sum = sum + body[i];
            link_bytes_due.push_back('{body[i], 1'b0, seen});
        end
        link_bytes_due.push_back('{~sum, closes_run, seen});
    endfunction

    function automatic void command_servos(light_set_t s);
        logic dark;
        dark = s.top_level < tracker_cfg.dark_threshold &&
               s.down_level < tracker_cfg.dark_threshold &&
               s.right_level < tracker_cfg.dark_threshold &&
               s.left_level < tracker_cfg.dark_threshold;
        if (dark)
        begin
            // home run: vertical first, angles untouched
            queue_packet(8'(SERVO_ID_VERT), PosW'(tracker_cfg.home_pos_vertical), 1'b0, 1'b0);
            queue_packet(8'(SERVO_ID_HORIZ), PosW'(tracker_cfg.home_pos_horizontal),
                         1'b0, 1'b1);
        end
        else
        begin
            horiz_angle = step_angle(horiz_angle, s.top_level, s.down_level);
            vert_angle  = step_angle(vert_angle, s.right_level, s.left_level);
            queue_packet(8'(SERVO_ID_HORIZ), angle_to_word(horiz_angle), 1'b1, 1'b0);
            queue_packet(8'(SERVO_ID_VERT), angle_to_word(vert_angle), 1'b1, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [2:0] idx, logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GAIN:       tracker_cfg.gain                = val[4:0];
            CFG_DARK_THR:   tracker_cfg.dark_threshold      = val;
            CFG_ANGLE_MIN:  tracker_cfg.angle_min           = val[AngleW-1:0];
            CFG_ANGLE_MAX:  tracker_cfg.angle_max           = val[AngleW-1:0];
            CFG_MOVE_SPEED: tracker_cfg.move_speed          = val;
            CFG_HOME_VERT:  tracker_cfg.home_pos_vertical   = val;
            CFG_HOME_HORIZ: tracker_cfg.home_pos_horizontal = val;
            default: ;
        endcase
    endtask

    task automatic scramble_regs();
        bit         wild;
        logic [9:0] lo;
        logic [9:0] hi;
        wild = ($urandom_range(0, 3) == 0);
        if (wild)
        begin
            lo = 10'($urandom_range(0, 1023));
            hi = 10'($urandom_range(0, 1023));
        end
        else
        begin
            lo = 10'($urandom_range(0, 150));
            hi = 10'($urandom_range(150, 300));
        end
        // upper data bits beyond each register's width are noise
        cfg_write(CFG_GAIN, 10'($urandom_range(0, 1023)));
        cfg_write(CFG_DARK_THR,
                  10'(wild ? $urandom_range(0, 1023) : $urandom_range(100, 400)));
        cfg_write(CFG_ANGLE_MIN, lo);
        cfg_write(CFG_ANGLE_MAX, hi);
        cfg_write(CFG_MOVE_SPEED, 10'($urandom_range(0, 1023)));
        cfg_write(CFG_HOME_VERT, 10'($urandom_range(0, 1023)));
        cfg_write(CFG_HOME_HORIZ, 10'($urandom_range(0, 1023)));
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNUSED, 10'($urandom_range(0, 1023)));
        cfg_valid <= 1'b0;
    endtask

    task automatic offer(int t, int d, int r, int l);
        sample_q.push_back('{l[9:0], r[9:0], d[9:0], t[9:0]});
    endtask

    function automatic logic [9:0] near(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[9:0];
    endfunction

    function automatic light_set_t random_set();
        light_set_t s;
        int         mode, thr, base, spread;
        mode   = $urandom_range(0, 9);
        thr    = int'(tracker_cfg.dark_threshold);
        base   = $urandom_range(0, 1023);
        spread = $urandom_range(0, 64);
        if (mode < 2 && thr > 0)
        begin
            s.top_level   = 10'($urandom_range(0, thr - 1));
            s.down_level  = 10'($urandom_range(0, thr - 1));
            s.right_level = 10'($urandom_range(0, thr - 1));
            s.left_level  = 10'($urandom_range(0, thr - 1));
        end
        else if (mode < 7)
        begin
            // sensors close to each other, as when roughly aimed at the sun
            s.top_level   = near(base, spread);
            s.down_level  = near(base, spread);
            s.right_level = near(base, spread);
            s.left_level  = near(base, spread);
        end
        else
        begin
            s = light_set_t'({$urandom(), 8'($urandom())});
        end
        return s;
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (sample_q.size() != 0 || s_tvalid || link_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // sample set driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                command_servos(s_tdata);
                sets_taken <= sets_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap = src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_tdata  <= sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 13);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, once, while the sender keeps offering sets
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && sets_taken == hold_at)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // link byte monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        link_beat_t got;
        link_beat_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tlast, m_tuser};
                if (link_bytes_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%0t: link byte %h with nothing expected", $time, m_tdata);
                end
                else
                begin
                    want = link_bytes_due.pop_front();
                    if (got !== want)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("%0t: byte exp %h last %b seen %b, got %h last %b seen %b",
                                     $time, want.link_byte, want.last_byte, want.light_seen,
                                     got.link_byte, got.last_byte, got.light_seen);
                    end
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (sink_stall != 0)
            begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                sink_stall = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int pass;
        tracker_cfg = '{gain: 5'd1, dark_threshold: 10'd200, angle_min: 9'd100,
                        angle_max: 9'd200, move_speed: 10'd68,
                        home_pos_vertical: 10'd512, home_pos_horizontal: 10'd560};
        horiz_angle = ANGLE_RESET;
        vert_angle  = ANGLE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: dark edge, threshold edge, full swings both ways
        offer(0, 0, 0, 0);
        offer(199, 199, 199, 199);
        offer(200, 0, 0, 0);
        offer(1023, 1023, 1023, 1023);
        offer(0, 1023, 0, 1023);
        offer(1023, 0, 1023, 0);
        wait_idle();

        // zero gain with crossed limits: angles pinned at the upper limit
        cfg_write(CFG_GAIN, 10'd0);
        cfg_write(CFG_ANGLE_MIN, 10'd250);
        cfg_write(CFG_ANGLE_MAX, 10'd120);
        cfg_valid <= 1'b0;
        offer(1023, 0, 0, 1023);
        offer(512, 511, 3, 4);
        offer(5, 5, 5, 5);
        wait_idle();

        // extremes: angles up to 511 give position words past 1023
        cfg_write(CFG_GAIN, 10'd31);
        cfg_write(CFG_DARK_THR, 10'd1023);
        cfg_write(CFG_ANGLE_MIN, 10'd0);
        cfg_write(CFG_ANGLE_MAX, 10'd511);
        cfg_write(CFG_MOVE_SPEED, 10'd1023);
        cfg_write(CFG_HOME_VERT, 10'd1023);
        cfg_write(CFG_HOME_HORIZ, 10'd0);
        cfg_write(CFG_UNUSED, 10'h3FF);
        cfg_valid <= 1'b0;
        offer(0, 1023, 1023, 0);
        offer(1022, 1022, 1022, 1022);
        offer(1023, 1022, 0, 0);
        offer(1, 0, 0, 1);
        offer(1023, 0, 0, 1023);
        offer(1023, 1023, 0, 0);
        offer(0, 0, 1023, 1023);
        offer(512, 512, 1023, 512);
        wait_idle();

        // never dark, limits equal at 300, masked data bits
        cfg_write(CFG_DARK_THR, 10'd0);
        cfg_write(CFG_GAIN, 10'h3E1);
        cfg_write(CFG_ANGLE_MIN, 10'd300);
        cfg_write(CFG_ANGLE_MAX, 10'h32C);
        cfg_write(CFG_MOVE_SPEED, 10'd0);
        cfg_write(CFG_HOME_VERT, 10'd0);
        cfg_write(CFG_HOME_HORIZ, 10'd1023);
        cfg_valid <= 1'b0;
        offer(0, 0, 0, 0);
        offer(1023, 0, 1023, 0);
        offer(5, 900, 77, 600);
        offer(1023, 1023, 1023, 1023);
        wait_idle();

        for (pass = 0; pass < RANDOM_PASSES; pass++)
        begin
            scramble_regs();
            if (pass == 0)
            begin
                idle_on = 1'b1;
                hold_at = sets_taken + 8;
            end
            else
            begin
                // last pass runs at full rate on both sides
                idle_on = (pass != RANDOM_PASSES - 1) && ($urandom_range(0, 3) != 0);
            end
            repeat (SETS_PER_PASS) sample_q.push_back(random_set());
            wait_idle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sts_pkg.sv
hw/rtl/sts_regs.sv
hw/rtl/sts_datapath.sv
hw/rtl/sts_ctrl.sv
hw/rtl/sun_tracker_servo_commander.sv
hw/rtl/sts_checker.sv
test/tb.sv
